@@ rtl/core/vcg_pkg.sv @@
package vcg_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COEFF_BITS  = 16;

	localparam int LG_BITS = 24;
	localparam int MQ      = 30;

	localparam int SW      = VALUE_WIDTH + 4;
	localparam int AW      = VALUE_WIDTH + 2;
	localparam int EW      = $clog2(AW);
	localparam int LW      = EW + LG_BITS;
	localparam int CW      = COEFF_BITS + 1;
	localparam int CFG_W   = VALUE_WIDTH;
	localparam int LOG_LAT = LG_BITS + 2;
	localparam int DIV_LAT = MQ;

	localparam logic signed [SW-1:0] ONE_Q     = SW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] LOG_FLOOR = SW'(((1 << FRAC_BITS) + 50) / 100);
	localparam logic [CW-1:0]        COEFF_ONE = CW'(1) << COEFF_BITS;

	typedef enum logic [1:0] {
		K_MISS,
		K_ZERO,
		K_ONE,
		K_DIV
	} kind_t;

	typedef enum logic [2:0] {
		REG_RANGE_MIN,
		REG_RANGE_MAX,
		REG_LOG_MODE,
		REG_LOW_COLOR,
		REG_HIGH_COLOR,
		REG_MISSING_COLOR
	} reg_idx_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic                          available;
	} sample_t;

	typedef struct packed {
		logic [7:0]    red;
		logic [7:0]    green;
		logic [7:0]    blue;
		logic [CW-1:0] coefficient;
		logic          in_range;
	} color_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bm;
		rem = n;
		res = '0;
		bm  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bm > rem) begin
				bm = bm >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (bm != 0) begin
				if (rem >= res + bm) begin
					rem = rem - (res + bm);
					res = (res >> 1) + bm;
				end else begin
					res = res >> 1;
				end
				bm = bm >> 2;
			end
		end
		return res;
	endfunction

	function automatic logic [LG_BITS:1][MQ-1:0] gamma_tab();
		logic [LG_BITS:1][MQ-1:0] t;
		logic [63:0]              s;
		s = 64'd1 << (MQ - 1);
		for (int k = 1; k <= LG_BITS; k++) begin
			s    = isqrt64(s << MQ);
			t[k] = s[MQ-1:0];
		end
		return t;
	endfunction

endpackage

@@ rtl/core/value_to_color_gradient_unit.sv @@
// Maps a stream of signed Q15.16 samples to RGB888 colours on a two-colour gradient, linearly
// or logarithmically with gamma 1.4, and reports the Q1.16 coefficient used. The pipeline
// takes one sample per clock while its skid register is empty and returns one colour per
// sample, in order. The depth comes mainly from two 26-stage logarithm units in series, the
// 30-stage fraction divider and the 24-stage power multiplier chain. The user must write the
// range, mode and colour registers through the cfg port only while no sample is in flight;
// the block itself does not enforce it. A one-entry skid register holds a second result while
// one waits at the output, so the pipeline keeps taking samples until that register is full.
module value_to_color_gradient_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  vcg_pkg::sample_t          sample,
	output logic                      color_valid,
	input  logic                      color_ready,
	output vcg_pkg::color_t           color,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [vcg_pkg::CFG_W-1:0] cfg_data
);
	import vcg_pkg::*;

	localparam int N_ST = 4 + LOG_LAT + 2 + DIV_LAT + 1 + LOG_LAT + 3 + LG_BITS + 2;
	localparam int TW   = 32;
	localparam int D5_SH = 34;
	localparam logic [TW-1:0] DIV5_RECIP = 32'hCCCCCCCD;
	localparam logic [LG_BITS:1][MQ-1:0] GTAB = gamma_tab();

	typedef struct packed {
		kind_t         kind;
		logic [AW-1:0] ad;
		logic [AW-1:0] aw;
		logic          wpos;
	} lsb_t;

	typedef struct packed {
		kind_t         kind;
		logic [CW-1:0] lin;
	} gsb_t;

	typedef struct packed {
		kind_t         kind;
		logic [CW-1:0] lin;
		logic [MQ-1:0] u;
	} psb_t;

	logic signed [VALUE_WIDTH-1:0] min_q;
	logic signed [VALUE_WIDTH-1:0] max_q;
	logic                          log_q;
	logic [23:0]                   lowc_q;
	logic [23:0]                   highc_q;
	logic [23:0]                   missc_q;

	logic            en;
	logic [N_ST:1]   vld_q;
	logic            o_v_q;
	logic            sk_v_q;
	color_t          o_q;
	color_t          sk_q;
	color_t          res_c;

	sample_t         smp_s1;
	logic signed [SW-1:0] lo_c, hi_c, val_c, sft_c;
	logic            bad_c;
	logic signed [SW-1:0] lo_s2, hi_s2, val_s2;
	logic            bad_s2;
	logic signed [SW-1:0] lo_s3, hi_s3, val_s3, d_s3, w_s3;
	logic            bad_s3;
	logic [AW-1:0]   ad_c, aw_c;
	kind_t           kind_c4;
	lsb_t            sb4_s4;
	logic [AW-1:0]   lo_s4, hi_s4, val_s4;
	lsb_t            sb1_q [LOG_LAT];
	logic [LW-1:0]   lv_y, llo_y, lhi_y;
	logic [LW-1:0]   num_s5, den_s5;
	lsb_t            sb_s5;
	kind_t           kind_c6;
	kind_t           kind_s6;
	logic [AW-1:0]   dn_s6, dd_s6;
	kind_t           sb2_q [DIV_LAT];
	logic [MQ-1:0]   div_q;
	kind_t           kind_s7;
	logic [CW-1:0]   lin_s7;
	logic [MQ-1:0]   r_s7;
	gsb_t            sb3_q [LOG_LAT];
	logic [LW-1:0]   lg_y;
	logic [TW-1:0]   t_g1, x_g2;
	gsb_t            gs_g1, gs_g2;
	logic [2*TW-1:0] mul_c;
	psb_t            ps_g3;
	psb_t            sb4_q [LG_BITS];
	logic [MQ:0]     p_q [1:LG_BITS];
	logic [MQ:0]     pw_c;
	logic [CW-1:0]   coef_c;
	logic [CW-1:0]   coef_s8;
	logic            inr_s8;
	logic signed [26:0] prod_s9 [3];
	logic [CW-1:0]   coef_s9;
	logic            inr_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= VALUE_WIDTH'(ONE_Q);
			log_q   <= 1'b0;
			lowc_q  <= 24'h000000;
			highc_q <= 24'hFFFFFF;
			missc_q <= 24'hA0A0A4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_MIN:     min_q   <= cfg_data;
				REG_RANGE_MAX:     max_q   <= cfg_data;
				REG_LOG_MODE:      log_q   <= cfg_data[0];
				REG_LOW_COLOR:     lowc_q  <= cfg_data[23:0];
				REG_HIGH_COLOR:    highc_q <= cfg_data[23:0];
				REG_MISSING_COLOR: missc_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign en           = !sk_v_q;
	assign sample_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_ST-1:1], sample_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1 <= sample;
		end
	end

	always_comb begin
		lo_c  = SW'(min_q);
		hi_c  = SW'(max_q);
		val_c = SW'(smp_s1.sample_value);
		sft_c = ONE_Q - lo_c;
		if (log_q && lo_c < 0) begin
			hi_c  = hi_c + sft_c;
			val_c = val_c + sft_c;
			lo_c  = LOG_FLOOR;
		end
		bad_c = !smp_s1.available || (log_q && (lo_c <= 0 || hi_c <= 0 || val_c <= 0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2  <= lo_c;
			hi_s2  <= hi_c;
			val_s2 <= val_c;
			bad_s2 <= bad_c;
			lo_s3  <= lo_s2;
			hi_s3  <= hi_s2;
			val_s3 <= val_s2;
			bad_s3 <= bad_s2;
			d_s3   <= val_s2 - lo_s2;
			w_s3   <= hi_s2 - lo_s2;
		end
	end

	always_comb begin
		ad_c = AW'(d_s3[SW-1] ? -d_s3 : d_s3);
		aw_c = AW'(w_s3[SW-1] ? -w_s3 : w_s3);
		priority if (bad_s3 || w_s3 == 0) begin
			kind_c4 = K_MISS;
		end else if (d_s3 == 0) begin
			kind_c4 = K_ZERO;
		end else if (d_s3[SW-1] != w_s3[SW-1]) begin
			kind_c4 = K_MISS;
		end else if (ad_c > aw_c) begin
			kind_c4 = K_MISS;
		end else if (ad_c == aw_c) begin
			kind_c4 = K_ONE;
		end else begin
			kind_c4 = K_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb4_s4 <= '{kind: kind_c4, ad: ad_c, aw: aw_c, wpos: !w_s3[SW-1]};
			lo_s4  <= lo_s3[AW-1:0];
			hi_s4  <= hi_s3[AW-1:0];
			val_s4 <= val_s3[AW-1:0];
		end
	end

	vcg_log2 u_log_v (.clk(clk), .en(en), .x(val_s4), .y(lv_y));
	vcg_log2 u_log_lo (.clk(clk), .en(en), .x(lo_s4), .y(llo_y));
	vcg_log2 u_log_hi (.clk(clk), .en(en), .x(hi_s4), .y(lhi_y));

	always_ff @(posedge clk) begin
		if (en) begin
			sb1_q[0] <= sb4_s4;
			for (int i = 1; i < LOG_LAT; i++) begin
				sb1_q[i] <= sb1_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5  <= sb1_q[LOG_LAT-1];
			num_s5 <= sb1_q[LOG_LAT-1].wpos ? lv_y - llo_y : llo_y - lv_y;
			den_s5 <= sb1_q[LOG_LAT-1].wpos ? lhi_y - llo_y : llo_y - lhi_y;
		end
	end

	always_comb begin
		kind_c6 = sb_s5.kind;
		if (log_q && sb_s5.kind == K_DIV) begin
			priority if (den_s5 == 0) begin
				kind_c6 = K_MISS;
			end else if (num_s5 >= den_s5) begin
				kind_c6 = K_ONE;
			end else if (num_s5 == 0) begin
				kind_c6 = K_ZERO;
			end else begin
				kind_c6 = K_DIV;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s6 <= kind_c6;
			dn_s6   <= log_q ? AW'(num_s5) : sb_s5.ad;
			dd_s6   <= log_q ? AW'(den_s5) : sb_s5.aw;
		end
	end

	vcg_div u_div (.clk(clk), .en(en), .num(dn_s6), .den(dd_s6), .q(div_q));

	always_ff @(posedge clk) begin
		if (en) begin
			sb2_q[0] <= kind_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				sb2_q[i] <= sb2_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s7 <= (log_q && sb2_q[DIV_LAT-1] == K_DIV && div_q == 0) ? K_ZERO
				: sb2_q[DIV_LAT-1];
			lin_s7  <= CW'(div_q >> (MQ - COEFF_BITS));
			r_s7    <= div_q;
		end
	end

	vcg_log2 u_log_r (.clk(clk), .en(en), .x(AW'(r_s7)), .y(lg_y));

	always_ff @(posedge clk) begin
		if (en) begin
			sb3_q[0] <= '{kind: kind_s7, lin: lin_s7};
			for (int i = 1; i < LOG_LAT; i++) begin
				sb3_q[i] <= sb3_q[i-1];
			end
		end
	end

	assign mul_c = (2*TW)'(x_g2) * (2*TW)'(DIV5_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			t_g1  <= TW'(MQ << LG_BITS) - TW'(lg_y);
			gs_g1 <= sb3_q[LOG_LAT-1];
			x_g2  <= (t_g1 << 3) - t_g1;
			gs_g2 <= gs_g1;
			ps_g3 <= '{kind: gs_g2.kind, lin: gs_g2.lin, u: mul_c[D5_SH+MQ-1:D5_SH]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb4_q[0] <= ps_g3;
			for (int i = 1; i < LG_BITS; i++) begin
				sb4_q[i] <= sb4_q[i-1];
			end
		end
	end

	for (genvar k = 1; k <= LG_BITS; k++) begin : g_pow
		logic [MQ:0]      pp;
		logic             fb;
		logic [2*MQ:0]    pm;
		if (k == 1) begin : g_first
			assign pp = (MQ+1)'(1) << MQ;
			assign fb = ps_g3.u[LG_BITS-k];
		end else begin : g_next
			assign pp = p_q[k-1];
			assign fb = sb4_q[k-2].u[LG_BITS-k];
		end
		assign pm = (2*MQ+1)'(pp) * (2*MQ+1)'(GTAB[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				p_q[k] <= fb ? pm[2*MQ:MQ] : pp;
			end
		end
	end

	always_comb begin
		pw_c = p_q[LG_BITS] >> sb4_q[LG_BITS-1].u[MQ-1:LG_BITS];
		unique case (sb4_q[LG_BITS-1].kind)
			K_MISS:  coef_c = '0;
			K_ZERO:  coef_c = '0;
			K_ONE:   coef_c = COEFF_ONE;
			K_DIV:   coef_c = log_q ? CW'(pw_c >> (MQ - COEFF_BITS)) : sb4_q[LG_BITS-1].lin;
			default: coef_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s8 <= coef_c;
			inr_s8  <= sb4_q[LG_BITS-1].kind != K_MISS;
			coef_s9 <= coef_s8;
			inr_s9  <= inr_s8;
			for (int ch = 0; ch < 3; ch++) begin
				prod_s9[ch] <= 27'(signed'({1'b0, highc_q[23-8*ch -: 8]})
					- signed'({1'b0, lowc_q[23-8*ch -: 8]})) * 27'(signed'({1'b0, coef_s8}));
			end
		end
	end

	always_comb begin
		logic signed [26:0] qv [3];
		for (int ch = 0; ch < 3; ch++) begin
			qv[ch] = prod_s9[ch] >>> COEFF_BITS;
		end
		if (inr_s9) begin
			res_c.red         = lowc_q[23:16] + qv[0][7:0];
			res_c.green       = lowc_q[15:8] + qv[1][7:0];
			res_c.blue        = lowc_q[7:0] + qv[2][7:0];
			res_c.coefficient = coef_s9;
			res_c.in_range    = 1'b1;
		end else begin
			res_c.red         = missc_q[23:16];
			res_c.green       = missc_q[15:8];
			res_c.blue        = missc_q[7:0];
			res_c.coefficient = '0;
			res_c.in_range    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!o_v_q || color_ready) begin
			if (sk_v_q) begin
				o_v_q  <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				o_v_q <= vld_q[N_ST];
			end
		end else if (vld_q[N_ST] && en) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || color_ready) begin
			o_q <= sk_v_q ? sk_q : res_c;
		end else if (en) begin
			sk_q <= res_c;
		end
	end

	assign color_valid = o_v_q;
	assign color       = o_q;

endmodule

@@ rtl/core/vcg_log2.sv @@
module vcg_log2 (
	input  logic                   clk,
	input  logic                   en,
	input  logic [vcg_pkg::AW-1:0] x,
	output logic [vcg_pkg::LW-1:0] y
);
	import vcg_pkg::*;

	logic [AW-1:0]      x_s1;
	logic [EW-1:0]      e_s1;
	logic [EW-1:0]      e_c;
	logic [AW-1:0]      norm_c;
	logic [MQ:0]        m_q [LG_BITS+1];
	logic [LG_BITS-1:0] f_q [LG_BITS+1];
	logic [EW-1:0]      e_q [LG_BITS+1];

	always_comb begin
		e_c = '0;
		for (int i = 1; i < AW; i++) begin
			if (x[i]) begin
				e_c = EW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			e_s1 <= e_c;
		end
	end

	always_comb begin
		if (e_s1 >= EW'(MQ)) begin
			norm_c = x_s1 >> (e_s1 - EW'(MQ));
		end else begin
			norm_c = x_s1 << (EW'(MQ) - e_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_q[0] <= norm_c[MQ:0];
			f_q[0] <= '0;
			e_q[0] <= e_s1;
		end
	end

	for (genvar k = 1; k <= LG_BITS; k++) begin : g_sq
		logic [2*MQ+1:0] sq;
		logic [MQ+1:0]   sh;
		assign sq = (2*MQ+2)'(m_q[k-1]) * (2*MQ+2)'(m_q[k-1]);
		assign sh = sq[2*MQ+1:MQ];
		always_ff @(posedge clk) begin
			if (en) begin
				m_q[k] <= sh[MQ+1] ? sh[MQ+1:1] : sh[MQ:0];
				f_q[k] <= {f_q[k-1][LG_BITS-2:0], sh[MQ+1]};
				e_q[k] <= e_q[k-1];
			end
		end
	end

	assign y = {e_q[LG_BITS], f_q[LG_BITS]};

endmodule

@@ rtl/core/vcg_div.sv @@
module vcg_div (
	input  logic                   clk,
	input  logic                   en,
	input  logic [vcg_pkg::AW-1:0] num,
	input  logic [vcg_pkg::AW-1:0] den,
	output logic [vcg_pkg::MQ-1:0] q
);
	import vcg_pkg::*;

	logic [AW-1:0] r_q [1:MQ];
	logic [AW-1:0] d_q [1:MQ];
	logic [MQ-1:0] q_q [1:MQ];

	for (genvar k = 1; k <= MQ; k++) begin : g_step
		logic [AW-1:0] rp;
		logic [AW-1:0] dp;
		logic [MQ-1:0] qp;
		logic [AW:0]   r2;
		logic          ge;
		if (k == 1) begin : g_first
			assign rp = num;
			assign dp = den;
			assign qp = '0;
		end else begin : g_next
			assign rp = r_q[k-1];
			assign dp = d_q[k-1];
			assign qp = q_q[k-1];
		end
		assign r2 = {rp, 1'b0};
		assign ge = r2 >= {1'b0, dp};
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k] <= ge ? AW'(r2 - {1'b0, dp}) : AW'(r2);
				d_q[k] <= dp;
				q_q[k] <= {qp[MQ-2:0], ge};
			end
		end
	end

	assign q = q_q[MQ];

endmodule

@@ rtl/core/vcg_checker.sv @@
module vcg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            color_valid,
	input logic            color_ready,
	input vcg_pkg::color_t color
);
	import vcg_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && !color_ready |=> color_valid && $stable(color))
		else $error("result dropped or changed while stalled");

	a_miss_coef: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && !color.in_range |-> color.coefficient == 0)
		else $error("missing colour with nonzero coefficient");

	a_coef_max: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> color.coefficient <= COEFF_ONE)
		else $error("coefficient above one");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !color_valid)
		else $error("result shown right after reset");

endmodule

bind value_to_color_gradient_unit vcg_checker u_vcg_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import vcg_pkg::*;

	localparam longint LIMIT = 3000000;
	localparam longint LOG_FLOOR_RAW = ((64'sd1 << FRAC_BITS) + 50) / 100;

	logic clk, arst_n;
	logic sample_valid, sample_ready;
	sample_t sample;
	logic color_valid, color_ready;
	color_t color;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	value_to_color_gradient_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.color_valid(color_valid), .color_ready(color_ready), .color(color),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	longint rmin, rmax;
	bit logm;
	logic [23:0] c_low, c_high, c_miss;
	longint unsigned pow_tab [1:LG_BITS];

	sample_t pending [$];
	color_t colors_due [$];
	int errors, gap_in, gap_out;
	longint cycles;
	bit took, calm;

	function automatic longint unsigned frac_quot(longint unsigned num, longint unsigned den,
			int bits);
		longint unsigned r, q;
		r = num;
		q = 0;
		for (int i = 0; i < bits; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned log2_q24(longint unsigned x);
		int e;
		longint unsigned m, fr;
		e = 63;
		fr = 0;
		while (e > 0 && !x[e]) e--;
		m = (e >= MQ) ? (x >> (e - MQ)) : (x << (MQ - e));
		for (int i = 0; i < LG_BITS; i++) begin
			m = (m * m) >> MQ;
			fr = fr << 1;
			if (m >= (64'd2 << MQ)) begin
				m = m >> 1;
				fr = fr | 1;
			end
		end
		return (longint'(e) << LG_BITS) | fr;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, c;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if (c * c <= n) res = c;
		end
		return res;
	endfunction

	function automatic logic [CW-1:0] gamma_coeff(longint unsigned r);
		longint unsigned t, u, n, f, p;
		t = (longint'(MQ) << LG_BITS) - log2_q24(r);
		u = t * 7 / 5;
		n = u >> LG_BITS;
		f = u & ((64'd1 << LG_BITS) - 1);
		p = 64'd1 << MQ;
		for (int k = 1; k <= LG_BITS; k++)
			if (f[LG_BITS-k]) p = (p * pow_tab[k]) >> MQ;
		if (n >= 40) return '0;
		p = p >> n;
		return CW'(p >> (MQ - COEFF_BITS));
	endfunction

	function automatic color_t paint(sample_t s);
		longint v, lo, hi, d, w, sh, c1, c2, prod, q;
		longint unsigned ad, aw, num, den, r;
		logic [CW-1:0] cf;
		bit ok;
		color_t o;
		v = longint'(s.sample_value);
		lo = rmin;
		hi = rmax;
		ok = s.available;
		cf = '0;
		if (ok && logm) begin
			if (lo < 0) begin
				sh = -lo + (64'sd1 << FRAC_BITS);
				hi += sh;
				v += sh;
				lo = LOG_FLOOR_RAW;
			end
			if (lo <= 0 || hi <= 0 || v <= 0) ok = 0;
		end
		if (ok) begin
			d = v - lo;
			w = hi - lo;
			if (w == 0) ok = 0;
			else if (d == 0) cf = '0;
			else if ((d < 0) != (w < 0)) ok = 0;
			else begin
				ad = (d < 0) ? -d : d;
				aw = (w < 0) ? -w : w;
				if (ad > aw) ok = 0;
				else if (ad == aw) cf = COEFF_ONE;
				else if (!logm) cf = CW'(frac_quot(ad, aw, COEFF_BITS));
				else begin
					num = (w > 0) ? log2_q24(v) - log2_q24(lo) : log2_q24(lo) - log2_q24(v);
					den = (w > 0) ? log2_q24(hi) - log2_q24(lo) : log2_q24(lo) - log2_q24(hi);
					if (den == 0) ok = 0;
					else if (num >= den) cf = COEFF_ONE;
					else begin
						r = (num == 0) ? 0 : frac_quot(num, den, MQ);
						cf = (r == 0) ? '0 : gamma_coeff(r);
					end
				end
			end
		end
		if (!ok) begin
			o.red = c_miss[23:16];
			o.green = c_miss[15:8];
			o.blue = c_miss[7:0];
			o.coefficient = '0;
			o.in_range = 1'b0;
			return o;
		end
		for (int ch = 0; ch < 3; ch++) begin
			c1 = (c_low >> (16 - 8 * ch)) & 8'hFF;
			c2 = (c_high >> (16 - 8 * ch)) & 8'hFF;
			prod = (c2 - c1) * longint'(cf);
			if (prod >= 0) q = prod >>> COEFF_BITS;
			else q = -((-prod + (64'sd1 << COEFF_BITS) - 1) >>> COEFF_BITS);
			case (ch)
				0: o.red = 8'(c1 + q);
				1: o.green = 8'(c1 + q);
				default: o.blue = 8'(c1 + q);
			endcase
		end
		o.coefficient = cf;
		o.in_range = 1'b1;
		return o;
	endfunction

	task automatic report(string what, color_t got, color_t want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		color_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		took <= sample_valid && sample_ready;
		if (color_valid && color_ready) begin
			if (colors_due.size() == 0) report("unexpected color", color, color);
			else begin
				want = colors_due.pop_front();
				if (color.red !== want.red) report("red", color, want);
				if (color.green !== want.green) report("green", color, want);
				if (color.blue !== want.blue) report("blue", color, want);
				if (color.coefficient !== want.coefficient) report("coefficient", color, want);
				if (color.in_range !== want.in_range) report("in_range", color, want);
			end
		end
		if (sample_valid && sample_ready) colors_due.push_back(paint(sample));
	end

	always @(negedge clk) begin
		if (!sample_valid || took) begin
			if (gap_in > 0) begin
				gap_in--;
				sample_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				gap_in = $urandom_range(0, 7);
				sample_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				sample <= pending.pop_front();
				sample_valid <= 1'b1;
			end else sample_valid <= 1'b0;
		end
		if (gap_out > 0) begin
			gap_out--;
			color_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			gap_out = $urandom_range(0, 7);
			color_ready <= 1'b0;
		end else color_ready <= 1'b1;
	end

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_RANGE_MIN: rmin = longint'(signed'(val));
			REG_RANGE_MAX: rmax = longint'(signed'(val));
			REG_LOG_MODE: logm = val[0];
			REG_LOW_COLOR: c_low = val[23:0];
			REG_HIGH_COLOR: c_high = val[23:0];
			default: c_miss = val[23:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(longint lo, longint hi, bit lg);
		write_reg(REG_RANGE_MIN, CFG_W'(lo));
		write_reg(REG_RANGE_MAX, CFG_W'(hi));
		write_reg(REG_LOG_MODE, CFG_W'(lg));
		write_reg(REG_LOW_COLOR, CFG_W'($urandom));
		write_reg(REG_HIGH_COLOR, CFG_W'($urandom));
		write_reg(REG_MISSING_COLOR, CFG_W'($urandom));
	endtask

	task automatic push(longint v, bit av);
		sample_t s;
		s.sample_value = VALUE_WIDTH'(v);
		s.available = av;
		pending.push_back(s);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending.size() != 0 || sample_valid || colors_due.size() != 0);
		repeat (130) @(posedge clk);
	endtask

	task automatic random_items(int count);
		longint a, b, lo, hi, v;
		longint unsigned span;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			a = rmin;
			b = rmax;
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			span = hi - lo + 1;
			if (pick == 0) v = rmin;
			else if (pick == 1) v = rmax;
			else if (pick < 4) v = longint'(signed'(32'($urandom)));
			else v = lo + longint'({$urandom, $urandom} % span);
			push(v, $urandom_range(0, 15) != 0);
		end
	endtask

	task automatic random_range(output longint lo, output longint hi);
		case ($urandom_range(0, 3))
			0: begin
				lo = longint'(signed'(32'($urandom)));
				hi = longint'(signed'(32'($urandom)));
			end
			1: begin
				lo = $urandom_range(1, 1 << 20);
				hi = lo + $urandom_range(1, 1 << 24);
			end
			2: begin
				lo = -longint'($urandom_range(1, 1 << 22));
				hi = $urandom_range(0, 1 << 23);
			end
			default: begin
				hi = $urandom_range(1, 1 << 18);
				lo = hi + $urandom_range(1, 1 << 20);
			end
		endcase
	endtask

	initial begin
		longint lo, hi;
		rmin = 0;
		rmax = 64'sd1 << FRAC_BITS;
		logm = 0;
		c_low = 24'h000000;
		c_high = 24'hFFFFFF;
		c_miss = 24'hA0A0A4;
		for (int k = 1; k <= LG_BITS; k++)
			pow_tab[k] = root_floor(((k == 1) ? (64'd1 << (MQ - 1)) : pow_tab[k-1]) << MQ);
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		color_ready = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;

		push(0, 1); push(65536, 1); push(32768, 1); push(1, 1); push(65535, 1);
		push(-1, 1); push(65537, 1); push(32'h7FFFFFFF, 1); push(-(64'sd1 << 31), 1);
		push(32768, 0);
		drain();
		setup(-(64'sd1 << 31), (64'sd1 << 31) - 1, 0);
		push(-(64'sd1 << 31), 1); push((64'sd1 << 31) - 1, 1); push(0, 1); push(-1, 1);
		drain();
		setup(65536, 100 * 65536, 1);
		push(65536, 1); push(100 * 65536, 1); push(65537, 1); push(10 * 65536, 1);
		push(0, 1); push(-5, 1); push(101 * 65536, 1);
		drain();
		setup(-3 * 65536, 5 * 65536, 1);
		push(-3 * 65536, 1); push(5 * 65536, 1); push(0, 1); push(-3 * 65536 - 1, 1);
		drain();
		setup(1000, 1000, 0);
		push(1000, 1); push(999, 1);
		drain();
		setup(5 * 65536, 65536, 1);
		push(3 * 65536, 1); push(65536, 1); push(5 * 65536, 1);
		drain();
		setup(655, 656, 1);
		push(655, 1); push(656, 1);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			random_range(lo, hi);
			setup(lo, hi, $urandom_range(0, 1));
			if (ph == 8) calm = 1;
			random_items(100);
			drain();
		end

		if (errors == 0 && colors_due.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/vcg_pkg.sv
rtl/core/vcg_log2.sv
rtl/core/vcg_div.sv
rtl/core/value_to_color_gradient_unit.sv
rtl/core/vcg_checker.sv
sim/tb.sv
